FILE: src/lkv_pkg.sv
package lkv_pkg;

  // Width of the capacity register.
  localparam int unsigned CAP_BITS = 5;

  // Capacity after reset.
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Outcome of one lookup in the tag array, valid while an item is processed.
  typedef struct packed {
    logic hit;     // key present before this access
    logic insert;  // put of a new key, a slot gets written
    logic evict;   // the oldest entry leaves to make room
  } lookup_t;

endpackage

FILE: src/lkv_intf.sv
interface lkv_req_if #(
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface lkv_rsp_if #(
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned VALUE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

interface lkv_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [lkv_pkg::CAP_BITS-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/lkv_ram.sv
module lkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read and a write to the same address in one cycle return the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/lkv_tag_array.sv
module lkv_tag_array #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 16,
  localparam int unsigned IDX_W      = $clog2(MAX_ENTRIES),
  localparam int unsigned CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  lkv_pkg::op_e     op_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [CNT_W-1:0] cap_i,
  output lkv_pkg::lookup_t lookup_o,
  output logic [IDX_W-1:0] hit_idx_o,
  output logic [IDX_W-1:0] victim_idx_o,
  output logic [IDX_W-1:0] slot_o
);
  import lkv_pkg::*;

  localparam int unsigned AGE_W = IDX_W;

  logic [KEY_BITS-1:0]  key_q   [MAX_ENTRIES];
  logic [AGE_W-1:0]     age_q   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]     count_q;

  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] victim_vec;
  logic [AGE_W-1:0]     hit_age;
  logic [AGE_W-1:0]     last_age;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     victim_idx;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     slot;
  lookup_t              lookup;

  // Valid ages always run 0 .. count-1 without gaps, so the oldest entry is
  // the one whose age equals count-1.
  assign last_age = AGE_W'(count_q - CNT_W'(1));

  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    hit_age    = '0;
    free_idx   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i]    = valid_q[i] && (key_q[i] == key_i);
      victim_vec[i] = valid_q[i] && (age_q[i] == last_age);
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_age = hit_age | age_q[i];
      end
      if (victim_vec[i]) begin
        victim_idx = victim_idx | IDX_W'(i);
      end
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    lookup.hit    = |hit_vec;
    lookup.insert = (op_i == OP_PUT) && !lookup.hit;
    lookup.evict  = lookup.insert && (count_q >= cap_i);
    // An evicted entry hands its slot straight to the new key.
    slot          = lookup.evict ? victim_idx : free_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else if (step_i) begin
      if (lookup.hit) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (hit_vec[i]) begin
            age_q[i] <= '0;
          end else if (valid_q[i] && (age_q[i] < hit_age)) begin
            age_q[i] <= age_q[i] + AGE_W'(1);
          end
        end
      end else if (lookup.insert) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (IDX_W'(i) == slot) begin
            valid_q[i] <= 1'b1;
            age_q[i]   <= '0;
          end else if (valid_q[i]) begin
            age_q[i] <= age_q[i] + AGE_W'(1);
          end
        end
        if (!lookup.evict) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (step_i && lookup.insert && (IDX_W'(i) == slot)) begin
        key_q[i] <= key_i;
      end
    end
  end

  assign lookup_o     = lookup;
  assign hit_idx_o    = hit_idx;
  assign victim_idx_o = victim_idx;
  assign slot_o       = slot;

endmodule

FILE: src/lru_key_value_cache.sv
// Fully associative key/value cache with least recently used replacement.
//
// Channels: req_i takes one word per access (operation 0 is a get, 1 is a
// put, with key and value), rsp_o returns one word per access (hit,
// read_value, evicted, evicted_key), and cfg_i writes the capacity register.
// All three move a word at a clock edge where valid and ready are both high.
// cfg_i is always ready; write it only while no access is in flight.
//
// An accepted word reaches rsp_o at the next edge that finds the result register empty
// or being drained. Throughput is one word per cycle while results are taken, set by
// the single pass through the key compare array and the registered value memory read.
//
// Reset empties the cache at once (all valid marks clear, count zero) and
// sets the capacity to 16; no clearing pass is needed. When the receiver
// stalls, the result word holds on rsp_o, one more request is taken into the
// input register, and req_i.ready then drops until the result is taken.
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lkv_req_if.sink    req_i,
  lkv_rsp_if.source  rsp_o,
  lkv_cfg_if.sink    cfg_i
);
  import lkv_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  // Wide enough for both the raw register and the entry count.
  localparam int unsigned CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  // Capacity register.
  logic [CAP_BITS-1:0] cap_q;
  logic [CMP_W-1:0]    cap_wide;
  logic [CNT_W-1:0]    cap_eff;

  // Input register.
  logic                  req_vld_q;
  op_e                   op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  // Result register; the two data fields come from the memories' read ports.
  logic rsp_vld_q;
  logic hit_q;
  logic rd_sel_q;
  logic evicted_q;

  logic             advance;
  logic             step;
  lookup_t          lookup;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] victim_idx;
  logic [IDX_W-1:0] slot;

  logic [VALUE_BITS-1:0] val_rdata;
  logic [KEY_BITS-1:0]   key_rdata;

  // The stage moves whenever the result register is empty or being drained.
  assign advance = !rsp_vld_q || rsp_o.ready;
  assign step    = req_vld_q && advance;

  assign req_i.ready = !req_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  // A capacity of zero acts as one, and anything above the table size acts
  // as the table size.
  always_comb begin
    cap_wide = CMP_W'(cap_q);
    if (cap_wide == '0) begin
      cap_wide = CMP_W'(1);
    end else if (cap_wide > CMP_W'(MAX_ENTRIES)) begin
      cap_wide = CMP_W'(MAX_ENTRIES);
    end
    cap_eff = CNT_W'(cap_wide);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      req_vld_q <= 1'b1;
    end else if (step) begin
      req_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q  <= op_e'(req_i.operation);
      key_q <= req_i.key;
      val_q <= req_i.value;
    end
  end

  lkv_tag_array #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_tags (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .op_i         (op_q),
    .key_i        (key_q),
    .cap_i        (cap_eff),
    .lookup_o     (lookup),
    .hit_idx_o    (hit_idx),
    .victim_idx_o (victim_idx),
    .slot_o       (slot)
  );

  // Values: a put writes its slot, and every access reads the hit slot. A put to a
  // present key reads and writes one slot in the same cycle; the read returns the old word.
  lkv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (step && (op_q == OP_PUT)),
    .waddr_i (lookup.hit ? hit_idx : slot),
    .wdata_i (val_q),
    .re_i    (step),
    .raddr_i (hit_idx),
    .rdata_o (val_rdata)
  );

  // Second copy of the keys, read at the victim slot. On an eviction the new
  // key goes into that same slot in the same cycle, and the read returns the
  // old key.
  lkv_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (step && lookup.insert),
    .waddr_i (slot),
    .wdata_i (key_q),
    .re_i    (step),
    .raddr_i (victim_idx),
    .rdata_o (key_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      rd_sel_q  <= 1'b0;
      evicted_q <= 1'b0;
    end else if (step) begin
      rsp_vld_q <= 1'b1;
      hit_q     <= lookup.hit;
      rd_sel_q  <= lookup.hit && (op_q == OP_GET);
      evicted_q <= lookup.evict;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.hit         = hit_q;
  assign rsp_o.read_value  = rd_sel_q ? val_rdata : '0;
  assign rsp_o.evicted     = evicted_q;
  assign rsp_o.evicted_key = evicted_q ? key_rdata : '0;

`ifndef SYNTHESIS
  // An eviction only ever happens for a put of a key that was absent.
  a_evict_needs_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && lookup.evict |-> lookup.insert && !lookup.hit)
    else $error("eviction without an insert of a new key");

  // Every processed access leaves a result word behind.
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> rsp_vld_q)
    else $error("processed access left no result");

  // Requests are held back only when both registers are full and stalled.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> req_vld_q && rsp_vld_q && !rsp_o.ready)
    else $error("request port stalled without a full pipeline");
`endif

endmodule
